// ----- src/agse_pkg.sv -----
// Shared types, widths and codes of the all-gather-v schedule engine.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package agse_pkg;

    localparam int MAX_RANKS = 64;   // depth of the count store and largest rank count
    localparam int COUNT_W   = 24;   // width of one stored element count
    localparam int NW        = 7;    // width of a rank count or a rank number
    localparam int DW        = 8;    // width of the step distance and step counter
    localparam int SW        = 31;   // width of an exact sum of counts
    localparam int EB_W      = 9;    // width of the element size
    localparam int THR_W     = 32;   // width of a byte threshold
    localparam int PROD_W    = 40;   // width of a byte product
    localparam int CHUNK_W   = 32;   // width of the ring chunk
    localparam int RES_W     = 30;   // width of an emitted count
    localparam int RANK_W    = 6;    // width of an emitted rank
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [SW-1:0] RES_MAX = SW'(30'h3FFF_FFFF);

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_RANKS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MY_RANK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_BYTES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_THR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIPE_THR   = 3'd5;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [1:0] OP_NONE     = 2'd0;
    localparam logic [1:0] OP_SENDRECV = 2'd1;
    localparam logic [1:0] OP_SEND     = 2'd2;
    localparam logic [1:0] OP_RECV     = 2'd3;

    localparam logic [1:0] ALG_RD    = 2'd0;
    localparam logic [1:0] ALG_BRUCK = 2'd1;
    localparam logic [1:0] ALG_RING  = 2'd2;

    typedef enum logic [5:0] {
        PH_LOAD  = 6'b000001,
        PH_RD    = 6'b000010,
        PH_BRUCK = 6'b000100,
        PH_BREM  = 6'b001000,
        PH_RING  = 6'b010000,
        PH_DONE  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic               cmd;
        logic [RANK_W-1:0]  rank_index;
        logic [COUNT_W-1:0] count;
    } req_t;

    typedef struct packed {
        logic [1:0]         op_kind;
        logic [1:0]         algorithm;
        logic [RES_W-1:0]   send_count;
        logic [RANK_W-1:0]  dest_rank;
        logic [RES_W-1:0]   recv_count;
        logic [RANK_W-1:0]  source_rank;
        logic               done_res;
    } rsp_t;

    // Clamp an exact sum to the emitted count width.
    function automatic logic [RES_W-1:0] sat_res(input logic [SW-1:0] v);
        logic [RES_W-1:0] r;
        r = (v > RES_MAX) ? '1 : v[RES_W-1:0];
        return r;
    endfunction

endpackage

// ----- src/agse_cnt_mem.sv -----
// Per-rank count memory: one write port and one read port with registered data.
// Depends on agse_pkg for the count width.
`timescale 1ns / 1ps

module agse_cnt_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [agse_pkg::COUNT_W-1:0] wdata,
    input  logic [AW-1:0]                raddr,
    output logic [agse_pkg::COUNT_W-1:0] rdata
);
    import agse_pkg::*;

    logic [COUNT_W-1:0] mem [DEPTH];
    logic [COUNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/agse_div.sv -----
// Restoring divider, one quotient bit per cycle, for the ring chunk size.
// Depends on agse_pkg for the threshold and element size widths.
`timescale 1ns / 1ps

module agse_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [agse_pkg::THR_W-1:0] dividend,
    input  logic [agse_pkg::EB_W-1:0]  divisor,
    output logic                       done,
    output logic [agse_pkg::THR_W-1:0] quotient
);
    import agse_pkg::*;

    localparam int CNT_W = $clog2(THR_W) + 1;

    logic [EB_W-1:0]  rem_reg, rem_next;
    logic [THR_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [EB_W:0]    shifted;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[THR_W-1]};
    assign fits    = (shifted >= {1'b0, divisor});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(THR_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? EB_W'(shifted - {1'b0, divisor}) : shifted[EB_W-1:0];
            quo_next = {quo_reg[THR_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/allgatherv_schedule_engine_top.sv -----
// Top level of the all-gather-v schedule engine: sequencer, run state and output word.
// Depends on agse_pkg, agse_cnt_mem and agse_div.
`timescale 1ns / 1ps

// The engine stores one element count per rank (load words) and answers each fetch
// word with the next point-to-point operation of this rank: recursive doubling,
// Bruck with a remainder step, or a chunked ring, chosen from the total bytes at the
// first fetch after a load. It handles one word at a time and drops its request
// side's stall only when the sequencer is idle; a finished word waits in the output
// register while the next request is taken. Every count is read through the single
// read port of the count memory, and that port sets the latency. A load goes through
// the emit state to the output register. The first fetch of a run reduces the rank,
// sums the counts and chooses the algorithm; a ring run then scans all counts for
// the minimum and, when the chunk comes from the pipeline threshold, runs the
// divider. A recursive doubling or Bruck step, the remainder step included, sums two
// windows of counts, and a ring word visits at most n + 2 positions.
module allgatherv_schedule_engine_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  agse_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output agse_pkg::rsp_t                 rsp,
    input  logic                           cfg_we,
    input  logic [agse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [agse_pkg::CFG_W-1:0]     cfg_data
);
    import agse_pkg::*;

    localparam int AW = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;

    typedef enum logic [17:0] {
        S_IDLE  = 18'b000000000000000001,
        S_MOD   = 18'b000000000000000010,
        S_WSUM  = 18'b000000000000000100,
        S_MUL   = 18'b000000000000001000,
        S_SEL   = 18'b000000000000010000,
        S_MIN   = 18'b000000000000100000,
        S_RL    = 18'b000000000001000000,
        S_CHUNK = 18'b000000000010000000,
        S_DIV   = 18'b000000000100000000,
        S_DISP  = 18'b000000001000000000,
        S_WB    = 18'b000000010000000000,
        S_WFIN  = 18'b000000100000000000,
        S_RCHK  = 18'b000001000000000000,
        S_RCS   = 18'b000010000000000000,
        S_RCR   = 18'b000100000000000000,
        S_RSTEP = 18'b001000000000000000,
        S_EMIT  = 18'b010000000000000000,
        S_SPARE = 18'b100000000000000000
    } state_t;

    // Configuration registers.
    logic [NW-1:0]    num_ranks_reg;
    logic [RANK_W-1:0] my_rank_reg;
    logic [EB_W-1:0]  elem_bytes_reg;
    logic [THR_W-1:0] long_thr_reg;
    logic [THR_W-1:0] short_thr_reg;
    logic [THR_W-1:0] pipe_thr_reg;

    // Sequencer and run state.
    state_t             state_reg, state_next;
    state_t             ws_ret_reg, ws_ret_next;
    phase_t             phase_reg, phase_next;
    logic [1:0]         alg_reg, alg_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [NW-1:0]      me_reg, me_next;
    logic [DW-1:0]      d_reg, d_next;
    logic [DW-1:0]      iter_reg, iter_next;
    logic [SW-1:0]      total_reg, total_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [NW-1:0]      ws_idx_reg, ws_idx_next;
    logic [NW-1:0]      ws_left_reg, ws_left_next;
    logic               ws_pend_reg, ws_pend_next;
    logic [NW-1:0]      pidx_reg, pidx_next;
    logic [SW-1:0]      acc_reg, acc_next;
    logic [SW-1:0]      sc_reg, sc_next;
    logic [COUNT_W-1:0] mn_reg, mn_next;
    logic [COUNT_W-1:0] cme_reg, cme_next;
    logic [COUNT_W-1:0] cright_reg, cright_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic [NW-1:0]      rs_idx_reg, rs_idx_next;
    logic [NW-1:0]      rr_idx_reg, rr_idx_next;
    logic [COUNT_W-1:0] soff_reg, soff_next;
    logic [COUNT_W-1:0] roff_reg, roff_next;
    logic [SW-1:0]      lts_reg, lts_next;
    logic [SW-1:0]      ltr_reg, ltr_next;
    logic [COUNT_W-1:0] cs_reg, cs_next;
    logic [COUNT_W-1:0] cr_reg, cr_next;
    logic [COUNT_W-1:0] sn0_reg, sn0_next;
    logic [COUNT_W-1:0] rn0_reg, rn0_next;
    rsp_t               res_reg, res_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    // Memory, divider and multiplier connections.
    logic               mem_we;
    logic [AW-1:0]      mem_raddr;
    logic [COUNT_W-1:0] mem_rdata;
    logic               div_start;
    logic               div_done;
    logic [THR_W-1:0]   div_q;
    logic [SW-1:0]      mul_a;
    logic [PROD_W-1:0]  mul_out;

    // Rank arithmetic on the latched run values.
    logic [DW-1:0]      n_ext;
    logic [DW-1:0]      src_sum;
    logic [DW-1:0]      dst_sum;
    logic [NW-1:0]      src_c;
    logic [NW-1:0]      dst_c;
    logic [NW-1:0]      partner_c;
    logic [NW-1:0]      mask_c;
    logic [NW-1:0]      right_c;
    logic [NW-1:0]      left_c;
    logic [NW-1:0]      ws_inc;
    logic [NW-1:0]      n_clamp;
    logic [EB_W-1:0]    eb_eff;
    logic               n_pow2;

    // Ring step amounts.
    logic [COUNT_W-1:0] sn1, rn1, sn, rn;
    logic [SW-1:0]      lts_new, ltr_new;
    logic [COUNT_W:0]   soff_sum, roff_sum;
    logic [DW-1:0]      d2;
    logic               fin;

    rsp_t               none_rsp;

    assign n_ext     = {1'b0, n_reg};
    assign src_sum   = {1'b0, me_reg} + d_reg;
    assign dst_sum   = {1'b0, me_reg} + n_ext - d_reg;
    assign src_c     = (src_sum >= n_ext) ? NW'(src_sum - n_ext) : NW'(src_sum);
    assign dst_c     = (dst_sum >= n_ext) ? NW'(dst_sum - n_ext) : NW'(dst_sum);
    assign partner_c = me_reg ^ NW'(d_reg);
    assign mask_c    = ~NW'(d_reg - 1'b1);
    assign right_c   = (me_reg + 1'b1 == n_reg) ? '0 : me_reg + 1'b1;
    assign left_c    = (me_reg == '0) ? n_reg - 1'b1 : me_reg - 1'b1;
    assign ws_inc    = (ws_idx_reg + 1'b1 == n_reg) ? '0 : ws_idx_reg + 1'b1;
    assign n_pow2    = ((n_reg & (n_reg - 1'b1)) == '0);
    assign eb_eff    = (elem_bytes_reg == '0) ? EB_W'(1) : elem_bytes_reg;
    assign d2        = d_reg << 1;

    // A rank count of zero counts as one; one above the store depth saturates.
    always_comb
    begin
        if (num_ranks_reg == '0)
        begin
            n_clamp = NW'(1);
        end
        else if (32'(num_ranks_reg) > MAX_RANKS)
        begin
            n_clamp = NW'(MAX_RANKS);
        end
        else
        begin
            n_clamp = num_ranks_reg;
        end
    end

    // One multiplier serves both the total bytes and the minimum chunk bytes.
    assign mul_a   = (state_reg == S_MUL) ? acc_reg : SW'(mn_reg);
    assign mul_out = PROD_W'(mul_a) * PROD_W'(eb_eff);

    // Ring step: clip each side to the chunk and to what is left.
    assign sn1      = (CHUNK_W'(sn0_reg) > chunk_reg) ? COUNT_W'(chunk_reg) : sn0_reg;
    assign rn1      = (CHUNK_W'(rn0_reg) > chunk_reg) ? COUNT_W'(chunk_reg) : rn0_reg;
    assign sn       = (SW'(sn1) > lts_reg) ? COUNT_W'(lts_reg) : sn1;
    assign rn       = (SW'(rn1) > ltr_reg) ? COUNT_W'(ltr_reg) : rn1;
    assign lts_new  = lts_reg - SW'(sn);
    assign ltr_new  = ltr_reg - SW'(rn);
    assign soff_sum = {1'b0, soff_reg} + {1'b0, sn};
    assign roff_sum = {1'b0, roff_reg} + {1'b0, rn};
    assign fin      = (lts_new == '0) && (ltr_new == '0);

    always_comb
    begin
        none_rsp             = '0;
        none_rsp.op_kind     = OP_NONE;
        none_rsp.algorithm   = alg_reg;
        none_rsp.done_res    = 1'b1;
    end

    agse_cnt_mem #(
        .DEPTH (MAX_RANKS),
        .AW    (AW)
    ) u_cnt_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (AW'(req.rank_index)),
        .wdata (req.count),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    agse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pipe_thr_reg),
        .divisor  (eb_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        ws_ret_next    = ws_ret_reg;
        phase_next     = phase_reg;
        alg_next       = alg_reg;
        n_next         = n_reg;
        me_next        = me_reg;
        d_next         = d_reg;
        iter_next      = iter_reg;
        total_next     = total_reg;
        prod_next      = prod_reg;
        ws_idx_next    = ws_idx_reg;
        ws_left_next   = ws_left_reg;
        ws_pend_next   = ws_pend_reg;
        pidx_next      = pidx_reg;
        acc_next       = acc_reg;
        sc_next        = sc_reg;
        mn_next        = mn_reg;
        cme_next       = cme_reg;
        cright_next    = cright_reg;
        chunk_next     = chunk_reg;
        rs_idx_next    = rs_idx_reg;
        rr_idx_next    = rr_idx_reg;
        soff_next      = soff_reg;
        roff_next      = roff_reg;
        lts_next       = lts_reg;
        ltr_next       = ltr_reg;
        cs_next        = cs_reg;
        cr_next        = cr_reg;
        sn0_next       = sn0_reg;
        rn0_next       = rn0_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_raddr      = AW'(ws_idx_reg);
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    iter_next = '0;
                    if (req.cmd == CMD_LOAD)
                    begin
                        mem_we     = (32'(req.rank_index) < MAX_RANKS);
                        phase_next = PH_LOAD;
                        res_next   = '0;
                        state_next = S_EMIT;
                    end
                    else if (phase_reg == PH_LOAD)
                    begin
                        n_next     = n_clamp;
                        me_next    = NW'(my_rank_reg);
                        state_next = S_MOD;
                    end
                    else
                    begin
                        state_next = S_DISP;
                    end
                end
            end

            // Reduce the rank modulo the rank count by repeated subtraction.
            S_MOD:
            begin
                if (me_reg >= n_reg)
                begin
                    me_next = me_reg - n_reg;
                end
                else
                begin
                    ws_idx_next  = '0;
                    ws_left_next = n_reg;
                    ws_pend_next = 1'b0;
                    acc_next     = '0;
                    ws_ret_next  = S_MUL;
                    state_next   = S_WSUM;
                end
            end

            // Window sum: one address a cycle, its data added in the next cycle.
            S_WSUM:
            begin
                if (ws_pend_reg)
                begin
                    acc_next = acc_reg + SW'(mem_rdata);
                end
                if (ws_left_reg != '0)
                begin
                    ws_left_next = ws_left_reg - 1'b1;
                    ws_idx_next  = ws_inc;
                    ws_pend_next = 1'b1;
                end
                else
                begin
                    ws_pend_next = 1'b0;
                    if (!ws_pend_reg)
                    begin
                        state_next = ws_ret_reg;
                    end
                end
            end

            S_MUL:
            begin
                total_next = acc_reg;
                prod_next  = mul_out;
                state_next = S_SEL;
            end

            S_SEL:
            begin
                d_next   = DW'(1);
                alg_next = ALG_RD;
                if (total_reg == '0)
                begin
                    phase_next = PH_DONE;
                    state_next = S_DISP;
                end
                else if (n_pow2 && (prod_reg < PROD_W'(long_thr_reg)))
                begin
                    phase_next = PH_RD;
                    state_next = S_DISP;
                end
                else if (prod_reg < PROD_W'(short_thr_reg))
                begin
                    alg_next   = ALG_BRUCK;
                    phase_next = PH_BRUCK;
                    state_next = S_DISP;
                end
                else
                begin
                    alg_next     = ALG_RING;
                    phase_next   = PH_RING;
                    ws_idx_next  = '0;
                    ws_left_next = n_reg;
                    ws_pend_next = 1'b0;
                    mn_next      = '1;
                    state_next   = S_MIN;
                end
            end

            // Scan all counts for the minimum and pick up this rank's count and its right neighbor's count.
            S_MIN:
            begin
                if (ws_pend_reg)
                begin
                    if (mem_rdata < mn_reg)
                    begin
                        mn_next = mem_rdata;
                    end
                    if (pidx_reg == me_reg)
                    begin
                        cme_next = mem_rdata;
                    end
                    if (pidx_reg == right_c)
                    begin
                        cright_next = mem_rdata;
                    end
                end
                if (ws_left_reg != '0)
                begin
                    pidx_next    = ws_idx_reg;
                    ws_left_next = ws_left_reg - 1'b1;
                    ws_idx_next  = ws_inc;
                    ws_pend_next = 1'b1;
                end
                else
                begin
                    ws_pend_next = 1'b0;
                    if (!ws_pend_reg)
                    begin
                        state_next = S_RL;
                    end
                end
            end

            S_RL:
            begin
                ltr_next    = total_reg - SW'(cme_reg);
                lts_next    = total_reg - SW'(cright_reg);
                prod_next   = mul_out;
                rs_idx_next = me_reg;
                rr_idx_next = left_c;
                soff_next   = '0;
                roff_next   = '0;
                state_next  = S_CHUNK;
            end

            S_CHUNK:
            begin
                if (prod_reg < PROD_W'(pipe_thr_reg))
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    chunk_next = (mn_reg == '0) ? CHUNK_W'(1) : CHUNK_W'(mn_reg);
                    state_next = S_DISP;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    chunk_next = (div_q == '0) ? CHUNK_W'(1) : CHUNK_W'(div_q);
                    state_next = S_DISP;
                end
            end

            // Decide what the current phase does on this fetch.
            S_DISP:
            begin
                acc_next     = '0;
                ws_pend_next = 1'b0;
                ws_ret_next  = S_WB;
                case (phase_reg)
                    PH_RD:
                    begin
                        if (d_reg < n_ext)
                        begin
                            ws_idx_next  = me_reg & mask_c;
                            ws_left_next = NW'(d_reg);
                            state_next   = S_WSUM;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                            res_next   = none_rsp;
                            state_next = S_EMIT;
                        end
                    end
                    PH_BRUCK:
                    begin
                        if (d_reg <= (n_ext >> 1))
                        begin
                            ws_idx_next  = me_reg;
                            ws_left_next = NW'(d_reg);
                            state_next   = S_WSUM;
                        end
                        else
                        begin
                            phase_next = PH_BREM;
                        end
                    end
                    PH_BREM:
                    begin
                        if (d_reg < n_ext)
                        begin
                            ws_idx_next  = me_reg;
                            ws_left_next = NW'(n_ext - d_reg);
                            state_next   = S_WSUM;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                            res_next   = none_rsp;
                            state_next = S_EMIT;
                        end
                    end
                    PH_RING:
                    begin
                        state_next = S_RCHK;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                        res_next   = none_rsp;
                        state_next = S_EMIT;
                    end
                endcase
            end

            // First window done; start the second one.
            S_WB:
            begin
                sc_next      = acc_reg;
                acc_next     = '0;
                ws_pend_next = 1'b0;
                ws_left_next = NW'(d_reg);
                ws_ret_next  = S_WFIN;
                state_next   = S_WSUM;
                case (phase_reg)
                    PH_RD:
                    begin
                        ws_idx_next = partner_c & mask_c;
                    end
                    PH_BRUCK:
                    begin
                        ws_idx_next = src_c;
                    end
                    default:
                    begin
                        ws_idx_next = me_reg;
                    end
                endcase
            end

            S_WFIN:
            begin
                res_next.op_kind    = OP_SENDRECV;
                res_next.algorithm  = alg_reg;
                res_next.send_count = sat_res(sc_reg);
                state_next          = S_EMIT;
                case (phase_reg)
                    PH_RD:
                    begin
                        d_next               = d2;
                        phase_next           = (d2 >= n_ext) ? PH_DONE : PH_RD;
                        res_next.dest_rank   = RANK_W'(partner_c);
                        res_next.recv_count  = sat_res(acc_reg);
                        res_next.source_rank = RANK_W'(partner_c);
                        res_next.done_res    = (d2 >= n_ext);
                    end
                    PH_BRUCK:
                    begin
                        d_next               = d2;
                        res_next.dest_rank   = RANK_W'(dst_c);
                        res_next.recv_count  = sat_res(acc_reg);
                        res_next.source_rank = RANK_W'(src_c);
                        res_next.done_res    = 1'b0;
                        if (d2 > (n_ext >> 1))
                        begin
                            if (d2 < n_ext)
                            begin
                                phase_next = PH_BREM;
                            end
                            else
                            begin
                                phase_next        = PH_DONE;
                                res_next.done_res = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        // Remainder step: receive whatever of the total is not held yet.
                        phase_next           = PH_DONE;
                        res_next.dest_rank   = RANK_W'(dst_c);
                        res_next.recv_count  = sat_res((total_reg > acc_reg) ?
                                                       total_reg - acc_reg : '0);
                        res_next.source_rank = RANK_W'(src_c);
                        res_next.done_res    = 1'b1;
                    end
                endcase
            end

            S_RCHK:
            begin
                if (((lts_reg == '0) && (ltr_reg == '0)) || (iter_reg == n_ext + DW'(2)))
                begin
                    phase_next = PH_DONE;
                    res_next   = none_rsp;
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_raddr  = AW'(rs_idx_reg);
                    state_next = S_RCS;
                end
            end

            S_RCS:
            begin
                cs_next    = mem_rdata;
                mem_raddr  = AW'(rr_idx_reg);
                state_next = S_RCR;
            end

            S_RCR:
            begin
                cr_next    = mem_rdata;
                sn0_next   = (cs_reg > soff_reg) ? cs_reg - soff_reg : '0;
                rn0_next   = (mem_rdata > roff_reg) ? mem_rdata - roff_reg : '0;
                state_next = S_RSTEP;
            end

            S_RSTEP:
            begin
                lts_next = lts_new;
                ltr_next = ltr_new;
                if (soff_sum >= {1'b0, cs_reg})
                begin
                    soff_next   = '0;
                    rs_idx_next = (rs_idx_reg == '0) ? n_reg - 1'b1 : rs_idx_reg - 1'b1;
                end
                else
                begin
                    soff_next = COUNT_W'(soff_sum);
                end
                if (roff_sum >= {1'b0, cr_reg})
                begin
                    roff_next   = '0;
                    rr_idx_next = (rr_idx_reg == '0) ? n_reg - 1'b1 : rr_idx_reg - 1'b1;
                end
                else
                begin
                    roff_next = COUNT_W'(roff_sum);
                end
                if ((sn == '0) && (rn == '0))
                begin
                    // Nothing moves at this position; try the next one in the same fetch.
                    iter_next  = iter_reg + 1'b1;
                    state_next = S_RCHK;
                end
                else
                begin
                    if (fin)
                    begin
                        phase_next = PH_DONE;
                    end
                    res_next           = '0;
                    res_next.algorithm = alg_reg;
                    res_next.done_res  = fin;
                    if (sn == '0)
                    begin
                        res_next.op_kind     = OP_RECV;
                        res_next.recv_count  = sat_res(SW'(rn));
                        res_next.source_rank = RANK_W'(left_c);
                    end
                    else if (rn == '0)
                    begin
                        res_next.op_kind    = OP_SEND;
                        res_next.send_count = sat_res(SW'(sn));
                        res_next.dest_rank  = RANK_W'(right_c);
                    end
                    else
                    begin
                        res_next.op_kind     = OP_SENDRECV;
                        res_next.send_count  = sat_res(SW'(sn));
                        res_next.dest_rank   = RANK_W'(right_c);
                        res_next.recv_count  = sat_res(SW'(rn));
                        res_next.source_rank = RANK_W'(left_c);
                    end
                    state_next = S_EMIT;
                end
            end

            // Hand the word to the output register once it is free.
            S_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_ranks_reg  <= NW'(1);
            my_rank_reg    <= '0;
            elem_bytes_reg <= EB_W'(1);
            long_thr_reg   <= THR_W'(524288);
            short_thr_reg  <= THR_W'(81920);
            pipe_thr_reg   <= THR_W'(32768);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_RANKS:  num_ranks_reg  <= cfg_data[NW-1:0];
                CFG_MY_RANK:    my_rank_reg    <= cfg_data[RANK_W-1:0];
                CFG_ELEM_BYTES: elem_bytes_reg <= cfg_data[EB_W-1:0];
                CFG_LONG_THR:   long_thr_reg   <= cfg_data[THR_W-1:0];
                CFG_SHORT_THR:  short_thr_reg  <= cfg_data[THR_W-1:0];
                CFG_PIPE_THR:   pipe_thr_reg   <= cfg_data[THR_W-1:0];
                default:        ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ws_ret_reg    <= S_IDLE;
            phase_reg     <= PH_LOAD;
            alg_reg       <= ALG_RD;
            n_reg         <= NW'(1);
            me_reg        <= '0;
            d_reg         <= DW'(1);
            iter_reg      <= '0;
            total_reg     <= '0;
            ws_idx_reg    <= '0;
            ws_left_reg   <= '0;
            ws_pend_reg   <= 1'b0;
            chunk_reg     <= CHUNK_W'(1);
            rs_idx_reg    <= '0;
            rr_idx_reg    <= '0;
            soff_reg      <= '0;
            roff_reg      <= '0;
            lts_reg       <= '0;
            ltr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_ret_reg    <= ws_ret_next;
            phase_reg     <= phase_next;
            alg_reg       <= alg_next;
            n_reg         <= n_next;
            me_reg        <= me_next;
            d_reg         <= d_next;
            iter_reg      <= iter_next;
            total_reg     <= total_next;
            ws_idx_reg    <= ws_idx_next;
            ws_left_reg   <= ws_left_next;
            ws_pend_reg   <= ws_pend_next;
            chunk_reg     <= chunk_next;
            rs_idx_reg    <= rs_idx_next;
            rr_idx_reg    <= rr_idx_next;
            soff_reg      <= soff_next;
            roff_reg      <= roff_next;
            lts_reg       <= lts_next;
            ltr_reg       <= ltr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        pidx_reg   <= pidx_next;
        acc_reg    <= acc_next;
        sc_reg     <= sc_next;
        mn_reg     <= mn_next;
        cme_reg    <= cme_next;
        cright_reg <= cright_next;
        cs_reg     <= cs_next;
        cr_reg     <= cr_next;
        sn0_reg    <= sn0_next;
        rn0_reg    <= rn0_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_load_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req.cmd == CMD_LOAD)) |=> (phase_reg == PH_LOAD))
        else $error("load word did not return the schedule to loading");

    a_ring_chunk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RSTEP) |-> (chunk_reg != '0))
        else $error("ring step with a zero chunk");

    a_rank_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_LOAD) |-> (me_reg < n_reg))
        else $error("run rank not below the rank count");

    a_none_moves_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.op_kind == OP_NONE)) |->
        ((rsp.send_count == '0) && (rsp.recv_count == '0)))
        else $error("word without an operation carries a count");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for the all-gather-v schedule engine: loads, fetches and register writes.
// Depends on agse_pkg and allgatherv_schedule_engine_top; predicts each answer word in place.
`timescale 1ns / 1ps

module testbench;
    import agse_pkg::*;

    localparam int NRANK    = 64;
    localparam int LIMIT    = 4000000;
    localparam int RAND_GOAL = 950;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    req_t                 req = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    allgatherv_schedule_engine_top u_top (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Words waiting to be offered, and answers predicted for accepted words.
    req_t pending_words[$];
    rsp_t expected_ops[$];
    int   errors = 0;
    int   cycles = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   hold_left = 0;
    bit   taken = 1'b0;

    // Register copies as the block sees them.
    longint unsigned reg_nr = 1, reg_me = 0, reg_eb = 1;
    longint unsigned reg_long = 524288, reg_short = 81920, reg_pipe = 32768;

    // Schedule state of the predictor.
    longint unsigned counts[NRANK];
    longint unsigned total;
    phase_t          cur_phase = PH_LOAD;
    int unsigned     step_dist = 1;
    int unsigned     snd_idx = 0, rcv_idx = 0;
    longint unsigned snd_off = 0, rcv_off = 0, snd_left = 0, rcv_left = 0;
    longint unsigned chunk = 1;
    int unsigned     grp_n = 1, grp_me = 0;
    logic [1:0]      grp_alg = ALG_RD;

    // Which count entries the stimulus has written so far.
    bit written[NRANK];

    function automatic longint unsigned group_sum(int unsigned start, int unsigned len);
        longint unsigned s;
        s = 0;
        for (int unsigned i = 0; i < len && i < grp_n; i++)
            s += counts[(start + i) % grp_n];
        return s;
    endfunction

    function automatic logic [RES_W-1:0] clamp30(longint unsigned v);
        return (v > 64'h3FFF_FFFF) ? {RES_W{1'b1}} : v[RES_W-1:0];
    endfunction

    function automatic rsp_t op_word(logic [1:0] kind, longint unsigned sc, int unsigned dr,
                                     longint unsigned rc, int unsigned sr, bit fin);
        rsp_t o;
        o.op_kind     = kind;
        o.algorithm   = grp_alg;
        o.send_count  = clamp30(sc);
        o.dest_rank   = dr[RANK_W-1:0];
        o.recv_count  = clamp30(rc);
        o.source_rank = sr[RANK_W-1:0];
        o.done_res    = fin;
        return o;
    endfunction

    // Latch the rank count and rank, sum the counts and pick the algorithm.
    function automatic void begin_schedule();
        longint unsigned n, eb, bytes, mn;
        n  = (reg_nr == 0) ? 1 : reg_nr;
        eb = (reg_eb == 0) ? 1 : reg_eb;
        if (n > NRANK)
            n = NRANK;
        grp_n  = 32'(n);
        grp_me = 32'(reg_me % n);
        total  = group_sum(0, grp_n);
        bytes  = total * eb;
        step_dist = 1;
        grp_alg = ALG_RD;
        if (total == 0)
        begin
            cur_phase = PH_DONE;
            return;
        end
        if ((grp_n & (grp_n - 1)) == 0 && bytes < reg_long)
        begin
            cur_phase = PH_RD;
        end
        else if (bytes < reg_short)
        begin
            grp_alg = ALG_BRUCK;
            cur_phase = PH_BRUCK;
        end
        else
        begin
            grp_alg = ALG_RING;
            cur_phase = PH_RING;
            rcv_left = total - counts[grp_me];
            snd_left = total - counts[(grp_me + 1) % grp_n];
            mn = counts[0];
            for (int unsigned i = 1; i < grp_n; i++)
                if (counts[i] < mn)
                    mn = counts[i];
            if (mn * eb < reg_pipe)
                mn = reg_pipe / eb;
            if (mn == 0)
                mn = 1;
            chunk   = mn;
            snd_idx = grp_me;
            rcv_idx = (grp_me + grp_n - 1) % grp_n;
            snd_off = 0;
            rcv_off = 0;
        end
    endfunction

    // Advance the predicted schedule by one word and return the answer it causes.
    function automatic rsp_t next_operation(req_t w);
        int unsigned n, me, d, src, dst, partner, lft, rgt;
        longint unsigned sc, rc, have, sn, rn, cs, cr;
        bit fin;
        if (w.cmd == CMD_LOAD)
        begin
            counts[w.rank_index] = w.count;
            cur_phase = PH_LOAD;
            return '0;
        end
        if (cur_phase == PH_LOAD)
            begin_schedule();
        n = grp_n;
        me = grp_me;
        d = step_dist;
        if (cur_phase == PH_RD)
        begin
            if (d < n)
            begin
                partner = me ^ d;
                sc = group_sum(me & ~(d - 1), d);
                rc = group_sum(partner & ~(d - 1), d);
                step_dist = d << 1;
                if (step_dist >= n)
                    cur_phase = PH_DONE;
                return op_word(OP_SENDRECV, sc, partner, rc, partner, cur_phase == PH_DONE);
            end
            cur_phase = PH_DONE;
        end
        if (cur_phase == PH_BRUCK)
        begin
            if (d <= n / 2)
            begin
                src = (me + d) % n;
                dst = (me + n - d) % n;
                sc = group_sum(me, d);
                rc = group_sum(src, d);
                step_dist = d << 1;
                if (step_dist > n / 2)
                    cur_phase = (step_dist < n) ? PH_BREM : PH_DONE;
                return op_word(OP_SENDRECV, sc, dst, rc, src, cur_phase == PH_DONE);
            end
            cur_phase = PH_BREM;
        end
        if (cur_phase == PH_BREM)
        begin
            cur_phase = PH_DONE;
            if (d < n)
            begin
                src = (me + d) % n;
                dst = (me + n - d) % n;
                sc = group_sum(me, n - d);
                have = group_sum(me, d);
                rc = (total > have) ? total - have : 0;
                return op_word(OP_SENDRECV, sc, dst, rc, src, 1'b1);
            end
        end
        if (cur_phase == PH_RING)
        begin
            lft = (me + n - 1) % n;
            rgt = (me + 1) % n;
            // Positions that would move nothing are stepped over within one fetch.
            for (int unsigned i = 0; i <= n + 1; i++)
            begin
                if (snd_left == 0 && rcv_left == 0)
                    break;
                cs = counts[snd_idx % n];
                cr = counts[rcv_idx % n];
                sn = (cs > snd_off) ? cs - snd_off : 0;
                rn = (cr > rcv_off) ? cr - rcv_off : 0;
                if (sn > chunk) sn = chunk;
                if (rn > chunk) rn = chunk;
                if (sn > snd_left) sn = snd_left;
                if (rn > rcv_left) rn = rcv_left;
                snd_left -= sn;
                rcv_left -= rn;
                snd_off += sn;
                rcv_off += rn;
                if (snd_off >= cs)
                begin
                    snd_off = 0;
                    snd_idx = (snd_idx + n - 1) % n;
                end
                if (rcv_off >= cr)
                begin
                    rcv_off = 0;
                    rcv_idx = (rcv_idx + n - 1) % n;
                end
                if (sn == 0 && rn == 0)
                    continue;
                fin = (snd_left == 0 && rcv_left == 0);
                if (fin)
                    cur_phase = PH_DONE;
                if (sn == 0)
                    return op_word(OP_RECV, 0, 0, rn, lft, fin);
                else if (rn == 0)
                    return op_word(OP_SEND, sn, rgt, 0, 0, fin);
                else
                    return op_word(OP_SENDRECV, sn, rgt, rn, lft, fin);
            end
            cur_phase = PH_DONE;
        end
        return op_word(OP_NONE, 0, 0, 0, 0, 1'b1);
    endfunction

    task automatic report(string field, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // Request side: prediction at the accepting edge, new words at the falling edge.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (rst_n && req_valid && !req_stall)
        begin
            expected_ops.push_back(next_operation(req));
            taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || taken))
        begin
            taken = 1'b0;
            if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                req <= pending_words.pop_front();
                req_valid <= 1'b1;
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Answer side: a long hold-off takes priority over the random stall.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_ops.size() == 0)
            begin
                $display("unexpected answer word at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = expected_ops.pop_front();
                if (rsp.op_kind != want.op_kind) report("op_kind", rsp.op_kind, want.op_kind);
                if (rsp.algorithm != want.algorithm)
                    report("algorithm", rsp.algorithm, want.algorithm);
                if (rsp.send_count != want.send_count)
                    report("send_count", rsp.send_count, want.send_count);
                if (rsp.dest_rank != want.dest_rank)
                    report("dest_rank", rsp.dest_rank, want.dest_rank);
                if (rsp.recv_count != want.recv_count)
                    report("recv_count", rsp.recv_count, want.recv_count);
                if (rsp.source_rank != want.source_rank)
                    report("source_rank", rsp.source_rank, want.source_rank);
                if (rsp.done_res != want.done_res)
                    report("done_res", rsp.done_res, want.done_res);
            end
        end
    end

    task automatic push_load(int unsigned idx, logic [COUNT_W-1:0] cnt);
        req_t w;
        w.cmd = CMD_LOAD;
        w.rank_index = idx[RANK_W-1:0];
        w.count = cnt;
        written[idx] = 1'b1;
        pending_words.push_back(w);
    endtask

    task automatic push_fetch(int unsigned k);
        req_t w;
        for (int unsigned i = 0; i < k; i++)
        begin
            w.cmd = CMD_FETCH;
            w.rank_index = RANK_W'($urandom);
            w.count = COUNT_W'($urandom);
            pending_words.push_back(w);
        end
    endtask

    // Wait until every offered word is taken and every answer has come back.
    task automatic drain();
        while (pending_words.size() > 0 || req_valid || expected_ops.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_NUM_RANKS:  reg_nr = val & 32'h7F;
            CFG_MY_RANK:    reg_me = val & 32'h3F;
            CFG_ELEM_BYTES: reg_eb = val & 32'h1FF;
            CFG_LONG_THR:   reg_long = val;
            CFG_SHORT_THR:  reg_short = val;
            CFG_PIPE_THR:   reg_pipe = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_threshold();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            3: return $urandom_range(1 << 14);
            default: return $urandom_range(1 << 22);
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count(int unsigned style);
        if ($urandom_range(9) == 0)
            return '0;
        case (style)
            0: return COUNT_W'($urandom_range(3));
            1: return COUNT_W'($urandom_range(2000));
            2: return COUNT_W'($urandom);
            default: return '0;
        endcase
    endfunction

    // One well-formed run: counts for every rank in use that has none yet and for some others, then a train of fetches.
    task automatic random_run(ref int made);
        int unsigned eff_n, style, k;
        eff_n = (reg_nr == 0) ? 1 : ((reg_nr > NRANK) ? NRANK : 32'(reg_nr));
        style = $urandom_range(3);
        for (int unsigned i = 0; i < NRANK; i++)
        begin
            if ((i < eff_n && (!written[i] || $urandom_range(2) == 0)) || $urandom_range(15) == 0)
            begin
                push_load(i, pick_count(style));
                made++;
            end
        end
        k = $urandom_range(1, 2 * eff_n + 6);
        push_fetch(k);
        made += k;
        // Now and then a load in the middle of a run restarts the schedule.
        if ($urandom_range(3) == 0)
        begin
            push_load($urandom_range(eff_n - 1), pick_count(style));
            k = $urandom_range(1, 4);
            push_fetch(k);
            made += 1 + k;
        end
    endtask

    initial
    begin
        int made;
        int ph_no;
        made = 0;
        ph_no = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero total, then a single rank, each with default registers.
        push_load(0, 24'h0);
        push_fetch(1);
        push_load(0, 24'hFF_FFFF);
        push_fetch(1);
        drain();
        // Four ranks, large total: the first fetches of a chunked ring.
        write_reg(CFG_NUM_RANKS, 4);
        write_reg(CFG_MY_RANK, 6);
        push_load(0, 24'h55);
        push_load(1, 24'hAA_AAAA);
        push_load(2, 24'h0);
        push_load(3, 24'h55_5555);
        push_fetch(3);
        drain();
        // Five ranks fall to Bruck with its remainder step.
        write_reg(CFG_NUM_RANKS, 5);
        write_reg(CFG_LONG_THR, 32'hFFFF_FFFF);
        write_reg(CFG_SHORT_THR, 32'hFFFF_FFFF);
        push_load(4, 24'd7);
        push_fetch(4);
        drain();
        // A ring over the same counts, with a zero count to step over.
        write_reg(CFG_SHORT_THR, 0);
        write_reg(CFG_ELEM_BYTES, 0);
        write_reg(CFG_PIPE_THR, 3);
        push_load(0, 24'd9);
        push_load(1, 24'd5);
        push_load(3, 24'd6);
        push_fetch(8);
        drain();

        // Random phases, cycling through the idling patterns.
        while (made < RAND_GOAL)
        begin
            case (ph_no % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 48; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 48; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            case ($urandom_range(6))
                0: write_reg(CFG_NUM_RANKS, 0);
                1: write_reg(CFG_NUM_RANKS, 127);
                2: write_reg(CFG_NUM_RANKS, 64);
                3: write_reg(CFG_NUM_RANKS, 1 << $urandom_range(5));
                default: write_reg(CFG_NUM_RANKS, $urandom_range(1, 64));
            endcase
            write_reg(CFG_MY_RANK, $urandom_range(63));
            case ($urandom_range(4))
                0: write_reg(CFG_ELEM_BYTES, 0);
                1: write_reg(CFG_ELEM_BYTES, 256);
                2: write_reg(CFG_ELEM_BYTES, 511);
                default: write_reg(CFG_ELEM_BYTES, $urandom_range(1, 16));
            endcase
            write_reg(CFG_LONG_THR, pick_threshold());
            write_reg(CFG_SHORT_THR, pick_threshold());
            write_reg(CFG_PIPE_THR, pick_threshold());
            if (ph_no == 1)
            begin
                // Hold the answer side off while words keep coming, so the input backs up.
                @(posedge clk);
                idle_pct = 0;
                hold_left = 400;
            end
            repeat (3) random_run(made);
            drain();
            ph_no++;
        end

        drain();
        repeat (50) @(negedge clk);
        if (errors == 0 && expected_ops.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
